@@ sv/fse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the edge-replicating FIR smoothing filter.
// No dependencies; every other file of the block imports this package.

package fse_pkg;

	localparam int SMP_W     = 16;
	localparam int COEF_W    = 16;
	localparam int PROD_W    = SMP_W + COEF_W;
	localparam int PSUM_W    = PROD_W + 1;
	localparam int SUM_W     = 34;
	localparam int NUM_COEF  = 7;
	localparam int CENTRE    = 3;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [SMP_W-1:0]  smp_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [PSUM_W-1:0] psum_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	// Weights after reset, oldest tap first
	localparam coef_t COEF_RESET [NUM_COEF] = '{
		16'sd1966, 16'sd1999, 16'sd7930, 16'sd12550, 16'sd7930, 16'sd1999, 16'sd1966
	};

	// Shift request from the sequencer to the row of cells
	typedef struct packed {
		logic shift;
		logic fill;
		smp_t x;
	} evt_t;

	// Tag riding along with the products of one window
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

endpackage

`default_nettype wire

@@ sv/fse_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sample channel: valid/ready handshake carrying one sample and its end flag.
// Depends on fse_pkg.

interface fse_in_if import fse_pkg::*; ();
	logic valid;
	logic ready;
	smp_t sample;
	logic final_sample;

	modport source(output valid, output sample, output final_sample, input ready);
	modport sink(input valid, input sample, input final_sample, output ready);
endinterface

`default_nettype wire

@@ sv/fse_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Result channel: valid/ready handshake carrying one smoothed value and its end flag.
// Depends on fse_pkg.

interface fse_out_if import fse_pkg::*; ();
	logic valid;
	logic ready;
	sum_t smoothed;
	logic stream_end;

	modport source(output valid, output smoothed, output stream_end, input ready);
	modport sink(input valid, input smoothed, input stream_end, output ready);
endinterface

`default_nettype wire

@@ sv/fse_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on fse_pkg.

interface fse_cfg_if import fse_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	coef_t    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/fse_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One delay-line cell: holds a sample, shifts from its right neighbour and
// registers the sample times its weight. Depends on fse_pkg.

module fse_cell import fse_pkg::*; (
	input  logic  clk,
	input  evt_t  evt,
	input  logic  adv,
	input  smp_t  nbr,
	input  coef_t coef,
	output smp_t  smp,
	output prod_t prod_s1
);

	smp_t smp_q;
	smp_t operand;

	// The first sample of a stream stands in for every older position
	assign operand = evt.fill ? evt.x : smp_q;
	assign smp     = smp_q;

	// Advance the delay line on every shift request
	always_ff @(posedge clk) begin
		if (evt.shift) begin
			smp_q <= evt.fill ? evt.x : nbr;
		end
	end

	// Register the tap product when the first stage moves
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= operand * coef;
		end
	end

endmodule

`default_nettype wire

@@ sv/fse_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Stream sequencer: takes samples, fills the delay line on a stream's first
// sample and issues the right-hand flush requests. Depends on fse_pkg, fse_in_if.

module fse_seq import fse_pkg::*; #(
	parameter int HALF = 3
) (
	input  logic clk,
	input  logic arst_n,
	fse_in_if.sink samples,
	input  logic adv1,
	output evt_t evt,
	output tag_t tag_s1
);

	localparam int CW = $clog2(HALF + 2);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t        state_q;
	logic [CW-1:0] seen_q;
	logic [CW-1:0] t_q;
	logic [CW-1:0] first_q;
	smp_t          x_q;
	tag_t          tag_q;

	logic          acc;
	logic          fl_ev;
	logic [CW-1:0] seen_base;
	logic [CW-1:0] seen_new;
	logic [CW-1:0] first_n;
	logic          emit_n;
	logic          fl_emit;
	logic          fl_last;

	assign samples.ready = adv1 && (state_q != ST_FLUSH);
	assign acc           = samples.valid && samples.ready;
	assign fl_ev         = (state_q == ST_FLUSH) && adv1;

	// Count samples of the open stream, saturating one past the half window
	assign seen_base = (state_q == ST_RUN) ? seen_q : '0;
	assign seen_new  = (seen_base > CW'(HALF)) ? seen_base : seen_base + CW'(1);
	assign emit_n    = (seen_new > CW'(HALF));
	assign first_n   = CW'(HALF + 1) - seen_new;
	assign fl_emit   = (t_q >= first_q);
	assign fl_last   = (t_q == CW'(HALF));

	assign evt.shift = acc || fl_ev;
	assign evt.fill  = acc && (state_q != ST_RUN);
	assign evt.x     = (state_q == ST_FLUSH) ? x_q : samples.sample;
	assign tag_s1    = tag_q;

	// Step the stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= '0;
			t_q     <= '0;
			first_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE, ST_RUN: begin
					if (acc) begin
						seen_q <= seen_new;
						if (samples.final_sample) begin
							state_q <= ST_FLUSH;
							t_q     <= CW'(1);
							first_q <= first_n;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_FLUSH: begin
					if (fl_ev) begin
						if (fl_last) begin
							state_q <= ST_IDLE;
						end else begin
							t_q <= t_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the last sample for the flush
	always_ff @(posedge clk) begin
		if (acc) begin
			x_q <= samples.sample;
		end
	end

	// Tag the window entering the first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (adv1) begin
			tag_q.valid <= (acc && emit_n) || (fl_ev && fl_emit);
			tag_q.last  <= fl_ev && fl_last;
		end
	end

`ifndef ASSERT_OFF
	a_final_starts_flush: assert property (@(posedge clk) disable iff (!arst_n)
		acc && samples.final_sample |=> state_q == ST_FLUSH)
		else $error("final sample did not start the flush");

	a_last_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		tag_q.last |-> tag_q.valid)
		else $error("stream end tagged on an empty slot");

	a_flush_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> t_q >= CW'(1) && t_q <= CW'(HALF))
		else $error("flush step out of range");
`endif

endmodule

`default_nettype wire

@@ sv/fse_sum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Registered adder tree over the tap products and the result register.
// Depends on fse_pkg, fse_out_if.

module fse_sum import fse_pkg::*; #(
	parameter int N = 7
) (
	input  logic  clk,
	input  logic  arst_n,
	input  prod_t prods_s1 [N],
	input  tag_t  tag_s1,
	output logic  adv1,
	fse_out_if.source results
);

	localparam int NP = (N + 1) / 2;

	psum_t pair   [NP];
	psum_t psum_s2 [NP];
	tag_t  tag_s2;
	sum_t  total;
	sum_t  sum_s3;
	tag_t  tag_s3;
	logic  en2;
	logic  en3;

	// A stage moves when it is empty or the next one moves
	assign en3  = !tag_s3.valid || results.ready;
	assign en2  = !tag_s2.valid || en3;
	assign adv1 = !tag_s1.valid || en2;

	// Add neighbouring products in pairs
	for (genvar i = 0; i < NP; i++) begin : g_pair
		if (2 * i + 1 < N) begin : g_two
			assign pair[i] = PSUM_W'(prods_s1[2*i]) + PSUM_W'(prods_s1[2*i+1]);
		end else begin : g_one
			assign pair[i] = PSUM_W'(prods_s1[2*i]);
		end
	end

	// Add the pair sums
	always_comb begin
		total = '0;
		for (int i = 0; i < NP; i++) begin
			total = total + SUM_W'(psum_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			psum_s2 <= pair;
		end
		if (en3) begin
			sum_s3 <= total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			if (en2) begin
				tag_s2 <= tag_s1;
			end
			if (en3) begin
				tag_s3 <= tag_s2;
			end
		end
	end

	assign results.valid      = tag_s3.valid;
	assign results.smoothed   = sum_s3;
	assign results.stream_end = tag_s3.last;

`ifndef ASSERT_OFF
	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid && !adv1 |=> tag_s1.valid)
		else $error("first stage dropped a window while stalled");
`endif

endmodule

`default_nettype wire

@@ sv/fir_smooth_edge_replicate.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Centred FIR smoothing filter with replicated edges, top level.
// Channels: samples (sample, final_sample) in, results (smoothed, stream_end)
// out, both valid/ready; cfg writes the weight of tap index 0..6 (index 7 is
// ignored) and is always ready. Write weights only while the filter is idle.
// Throughput: one sample per cycle unless the pipeline stalls or a flush
// runs. A sample flagged final_sample is followed by a flush of (TAPS-1)/2
// shift requests during which samples.ready is low. Registers from a request
// to its result, in order: tap product, pair sum and final sum.
// Result k of a stream appears once sample k+(TAPS-1)/2 has been taken; the
// first sample is replicated to the left, the final one to the right on flush.
// The last result of a stream carries stream_end.
// Reset: weights return to their defaults and no stream is open.
// Stall: a waiting result holds; the pipeline behind it keeps filling its
// empty stages, and samples.ready drops only once all stages are full.

module fir_smooth_edge_replicate import fse_pkg::*; #(
	parameter int TAPS = 7
) (
	input  logic clk,
	input  logic arst_n,
	fse_in_if.sink    samples,
	fse_out_if.source results,
	fse_cfg_if.sink   cfg
);

	localparam int HALF = (TAPS - 1) / 2;
	localparam int NTAP = 2 * HALF + 1;

	coef_t coef_q [NUM_COEF];
	evt_t  evt;
	tag_t  tag_s1;
	logic  adv1;
	smp_t  smp [2*HALF];
	prod_t prods_s1 [NTAP];
	prod_t prod_new_s1;

	// Take weight writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg.valid) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				if (cfg.index == CFG_IDX_W'(i)) begin
					coef_q[i] <= cfg.data;
				end
			end
		end
	end

	fse_seq #(.HALF(HALF)) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.adv1    (adv1),
		.evt     (evt),
		.tag_s1  (tag_s1)
	);

	// Row of delay-line cells, oldest first
	for (genvar p = 0; p < 2 * HALF; p++) begin : g_cell
		if (p == 2 * HALF - 1) begin : g_newest
			fse_cell u_cell (
				.clk     (clk),
				.evt     (evt),
				.adv     (adv1),
				.nbr     (evt.x),
				.coef    (coef_q[CENTRE-HALF+p]),
				.smp     (smp[p]),
				.prod_s1 (prods_s1[p])
			);
		end else begin : g_inner
			fse_cell u_cell (
				.clk     (clk),
				.evt     (evt),
				.adv     (adv1),
				.nbr     (smp[p+1]),
				.coef    (coef_q[CENTRE-HALF+p]),
				.smp     (smp[p]),
				.prod_s1 (prods_s1[p])
			);
		end
	end

	// Product of the incoming sample with the newest-tap weight
	always_ff @(posedge clk) begin
		if (adv1) begin
			prod_new_s1 <= evt.x * coef_q[CENTRE+HALF];
		end
	end

	assign prods_s1[2*HALF] = prod_new_s1;

	fse_sum #(.N(NTAP)) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.prods_s1 (prods_s1),
		.tag_s1   (tag_s1),
		.adv1     (adv1),
		.results  (results)
	);

endmodule

`default_nettype wire
